@@ hdl/bcc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Button click classifier package
// Shared widths, register indexes, reset values and event codes.
// ----------------------------------------------------------------------------
package bcc_pkg;

    localparam int COUNTER_BITS_DEF = 16;

    localparam int DEBOUNCE_W = 8;
    localparam int RETURN_W   = 16;
    localparam int LONG_W     = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RETURN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG     = 2'd2;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 8'd50;
    localparam logic [RETURN_W-1:0]   RETURN_RST   = 16'd250;
    localparam logic [LONG_W-1:0]     LONG_RST     = 16'd2000;

    typedef enum logic [1:0] {
        EVT_NONE   = 2'd0,
        EVT_SINGLE = 2'd1,
        EVT_DOUBLE = 2'd2,
        EVT_LONG   = 2'd3
    } event_t;

endpackage
`default_nettype wire

@@ hdl/bcc_intf.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Button click classifier channels
// Valid/ready channels for button samples, event reports and register writes.
// ----------------------------------------------------------------------------
interface bcc_sample_if;
    logic valid;
    logic ready;
    logic button_level;

    modport source (output valid, output button_level, input ready);
    modport sink   (input valid, input button_level, output ready);
endinterface

interface bcc_report_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_res;

    modport source (output valid, output event_res, input ready);
    modport sink   (input valid, input event_res, output ready);
endinterface

interface bcc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [bcc_pkg::CFG_IDX_W-1:0]  index;
    logic [bcc_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ hdl/button_click_classifier_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Button click classifier
// Classifies one button sample per request as single, double or long press.
// The report for a sample is registered and is valid in the cycle after the sample request is accepted.
// Throughput: one sample request per cycle while no report is stalled; the result register sets the rate.
// A stalled report only holds off new samples while it is still waiting.
// Reset clears all classifier state but the report event register, and restores the default thresholds.
// ----------------------------------------------------------------------------
module button_click_classifier_top #(
    parameter int COUNTER_BITS = bcc_pkg::COUNTER_BITS_DEF
) (
    input  wire           clk,
    input  wire           rst_n,
    bcc_sample_if.sink    sample,
    bcc_report_if.source  report,
    bcc_cfg_if.sink       cfg
);

    localparam int CMP_W = (COUNTER_BITS > bcc_pkg::LONG_W) ? COUNTER_BITS
                                                            : bcc_pkg::LONG_W;

    logic [bcc_pkg::DEBOUNCE_W-1:0] debounce_reg;
    logic [bcc_pkg::RETURN_W-1:0]   return_reg;
    logic [bcc_pkg::LONG_W-1:0]     long_reg;

    logic                    was_pressed_reg, was_pressed_next;
    bcc_pkg::event_t         click_reg, click_next;
    logic [COUNTER_BITS-1:0] hold_reg, hold_next;
    logic [COUNTER_BITS-1:0] release_reg, release_next;
    logic                    lock_reg, lock_next;
    bcc_pkg::event_t         event_reg, event_next;
    logic                    out_valid_reg;

    logic                    pressed;
    logic                    accept;
    logic [COUNTER_BITS-1:0] hold_inc;
    logic [COUNTER_BITS-1:0] release_inc;
    logic                    debounce_met;
    logic                    long_met;
    logic                    return_met;

    assign cfg.ready     = 1'b1;
    assign sample.ready  = !out_valid_reg || report.ready;
    assign accept        = sample.valid && sample.ready;
    assign report.valid  = out_valid_reg;
    assign report.event_res = event_reg;

    assign pressed     = !sample.button_level;
    assign hold_inc    = (&hold_reg) ? hold_reg : hold_reg + 1'b1;
    assign release_inc = (&release_reg) ? release_reg : release_reg + 1'b1;
    assign debounce_met = CMP_W'(hold_inc) >= CMP_W'(debounce_reg);
    assign long_met     = CMP_W'(hold_inc) >= CMP_W'(long_reg);

    always_comb
    begin
        hold_next        = hold_inc;
        release_next     = release_inc;
        click_next       = click_reg;
        lock_next        = lock_reg;
        was_pressed_next = pressed;
        event_next       = bcc_pkg::EVT_NONE;

        priority if (pressed && !was_pressed_reg)
        begin
            hold_next = '0;
        end
        else if (!pressed && lock_reg)
        begin
            lock_next = 1'b0;
        end
        else if (!pressed && was_pressed_reg && debounce_met &&
                 (click_reg == bcc_pkg::EVT_NONE || click_reg == bcc_pkg::EVT_SINGLE))
        begin
            release_next = '0;
            click_next   = (click_reg == bcc_pkg::EVT_NONE) ? bcc_pkg::EVT_SINGLE
                                                            : bcc_pkg::EVT_DOUBLE;
        end
        else if (pressed && long_met && !lock_reg)
        begin
            click_next = bcc_pkg::EVT_LONG;
        end
        else
        begin
            click_next = click_reg;
        end

        if (return_met && click_next != bcc_pkg::EVT_NONE)
        begin
            event_next = click_next;
            if (click_next == bcc_pkg::EVT_LONG)
            begin
                lock_next = 1'b1;
            end
            click_next = bcc_pkg::EVT_NONE;
        end
    end

    assign return_met = CMP_W'(release_next) >= CMP_W'(return_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= bcc_pkg::DEBOUNCE_RST;
            return_reg   <= bcc_pkg::RETURN_RST;
            long_reg     <= bcc_pkg::LONG_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                bcc_pkg::REG_DEBOUNCE: debounce_reg <= cfg.data[bcc_pkg::DEBOUNCE_W-1:0];
                bcc_pkg::REG_RETURN:   return_reg   <= cfg.data[bcc_pkg::RETURN_W-1:0];
                bcc_pkg::REG_LONG:     long_reg     <= cfg.data[bcc_pkg::LONG_W-1:0];
                default:               ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            was_pressed_reg <= 1'b0;
            click_reg       <= bcc_pkg::EVT_NONE;
            hold_reg        <= '0;
            release_reg     <= '0;
            lock_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else if (accept)
        begin
            was_pressed_reg <= was_pressed_next;
            click_reg       <= click_next;
            hold_reg        <= hold_next;
            release_reg     <= release_next;
            lock_reg        <= lock_next;
            out_valid_reg   <= 1'b1;
        end
        else if (report.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            event_reg <= event_next;
        end
    end

endmodule
`default_nettype wire

@@ hdl/bcc_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Button click classifier checker
// Port-level checks on request flow through the classifier.
// ----------------------------------------------------------------------------
module bcc_checker (
    input wire       clk,
    input wire       rst_n,
    input wire       in_valid,
    input wire       in_ready,
    input wire       out_valid,
    input wire       out_ready,
    input wire [1:0] event_res
);

    a_accept_gives_report: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> out_valid
    ) else $error("sample request did not produce a report");

    a_ready_when_empty: assert property (
        @(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready
    ) else $error("sample side stalled with no report pending");

    a_ready_when_drained: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready) |-> in_ready
    ) else $error("sample side stalled while report was taken");

    a_stalled_report_holds: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(event_res))
    ) else $error("stalled report changed");

endmodule

bind button_click_classifier_top bcc_checker u_bcc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (report.valid),
    .out_ready (report.ready),
    .event_res (report.event_res)
);
`default_nettype wire
